>>> src/mcgd_pkg.sv
`default_nettype none

package mcgd_pkg;

  localparam int unsigned NUM_MODULES_DEF = 32;
  localparam int unsigned MAX_REPORT      = 32;
  localparam int unsigned RCW             = $clog2(MAX_REPORT + 1);

  localparam int unsigned FUNC_W = 2;
  localparam int unsigned IDX_W  = 48;
  localparam int unsigned OFF_W  = 49;
  localparam int unsigned SLOT_W = 5;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned SEL_W  = 4;
  localparam int unsigned REC_W  = 6;
  localparam logic [REC_W-1:0] REC_MAX = '1;

  // input tdata layout
  localparam int unsigned S_IDX_LO  = 0;
  localparam int unsigned S_LOC_LO  = S_IDX_LO + IDX_W;
  localparam int unsigned S_SLOT_LO = S_LOC_LO + IDX_W;
  localparam int unsigned S_CNT_LO  = S_SLOT_LO + SLOT_W;
  localparam int unsigned S_VAL_LO  = S_CNT_LO + CNT_W;
  localparam int unsigned S_USED_W  = S_VAL_LO + VAL_W;
  localparam int unsigned S_TDATA_W = ((S_USED_W + 7) / 8) * 8;

  // output tdata layout
  localparam int unsigned M_IDX_LO  = 0;
  localparam int unsigned M_LOFF_LO = M_IDX_LO + IDX_W;
  localparam int unsigned M_SLOT_LO = M_LOFF_LO + OFF_W;
  localparam int unsigned M_SOFF_LO = M_SLOT_LO + SLOT_W;
  localparam int unsigned M_USED_W  = M_SOFF_LO + OFF_W;
  localparam int unsigned M_TDATA_W = ((M_USED_W + 7) / 8) * 8;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_START  = 2'd0,
    FUNC_RECORD = 2'd1,
    FUNC_END    = 2'd2
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_REC  = 4'b0010,
    ST_RD   = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  typedef struct packed {
    logic start;       // event start item taken
    logic rec_acc;     // counter record taken, table read issued
    logic rec_commit;  // compare and write back the record
    logic end_evt;     // event end item taken
    logic rep_start;   // begin a glitch report
    logic rd_rep;      // read the table at the report index
    logic rep_next;    // advance to the next reported slot
  } cmd_t;

  typedef struct packed {
    logic glitch;
    logic rep_last;
  } sts_t;

endpackage

`default_nettype wire

>>> src/module_counter_glitch_detector.sv
// Event counter glitch detector. Each event arrives as a start item (tuser 0) carrying the
// source index and local number, counter records (tuser 1), and an end item (tuser 2).
// Start and end items are handled on acceptance; a counter record is a table read, then a
// compare and write back to the offset table. After a glitched end item the block emits
// one result per slot in use, at most 32, or one empty result if none is in use; each is
// a table read, then output held until m_axis_tready; no input is taken during a report.
// The table clears at reset through per-entry valid bits, so no clearing pass is needed.
`default_nettype none

module module_counter_glitch_detector #(
  parameter int unsigned NUM_MODULES = mcgd_pkg::NUM_MODULES_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [mcgd_pkg::SEL_W-1:0]      cfg_wdata_i,    // counter_select
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // source_index, local_number, module_slot, counter_count, ctr_value
  input  wire logic [mcgd_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  input  wire logic [mcgd_pkg::FUNC_W-1:0]     s_axis_tuser,   // func
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // glitch_index, local_offset, slot_number, slot_offset
  output logic [mcgd_pkg::M_TDATA_W-1:0]       m_axis_tdata,
  output logic [0:0]                           m_axis_tuser,   // slot_valid
  output logic                                 m_axis_tlast    // last_result
);

  mcgd_pkg::cmd_t cmd;
  mcgd_pkg::sts_t sts;
  logic           slot_valid;

  mcgd_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .func_i        (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  mcgd_datapath #(
    .NUM_MODULES (NUM_MODULES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_data_i        (s_axis_tdata),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_data_o       (m_axis_tdata),
    .out_slot_valid_o (slot_valid)
  );

  assign m_axis_tuser[0] = slot_valid;
  assign m_axis_tlast    = sts.rep_last;

endmodule

`default_nettype wire

>>> src/mcgd_ctrl.sv
`default_nettype none

module mcgd_ctrl (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [mcgd_pkg::FUNC_W-1:0]  func_i,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  input  wire mcgd_pkg::sts_t               sts_i,
  output mcgd_pkg::cmd_t                    cmd_o
);

  mcgd_pkg::state_e state_q, state_d;
  logic in_acc;

  assign s_axis_tready = (state_q == mcgd_pkg::ST_IDLE);
  assign m_axis_tvalid = (state_q == mcgd_pkg::ST_OUT);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      mcgd_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (mcgd_pkg::func_e'(func_i))
            mcgd_pkg::FUNC_START: begin
              cmd_o.start = 1'b1;
            end
            mcgd_pkg::FUNC_RECORD: begin
              cmd_o.rec_acc = 1'b1;
              state_d       = mcgd_pkg::ST_REC;
            end
            mcgd_pkg::FUNC_END: begin
              cmd_o.end_evt = 1'b1;
              if (sts_i.glitch) begin
                cmd_o.rep_start = 1'b1;
                state_d         = mcgd_pkg::ST_RD;
              end
            end
            default: ;  // unknown code, item dropped
          endcase
        end
      end
      mcgd_pkg::ST_REC: begin
        cmd_o.rec_commit = 1'b1;
        state_d          = mcgd_pkg::ST_IDLE;
      end
      mcgd_pkg::ST_RD: begin
        cmd_o.rd_rep = 1'b1;
        state_d      = mcgd_pkg::ST_OUT;
      end
      mcgd_pkg::ST_OUT: begin
        if (m_axis_tready) begin
          if (sts_i.rep_last) begin
            state_d = mcgd_pkg::ST_IDLE;
          end else begin
            cmd_o.rep_next = 1'b1;
            state_d        = mcgd_pkg::ST_RD;
          end
        end
      end
      default: state_d = mcgd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mcgd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> src/mcgd_datapath.sv
`default_nettype none

module mcgd_datapath #(
  parameter int unsigned NUM_MODULES = mcgd_pkg::NUM_MODULES_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [mcgd_pkg::SEL_W-1:0]      cfg_wdata_i,
  input  wire logic [mcgd_pkg::S_TDATA_W-1:0]  in_data_i,
  input  wire mcgd_pkg::cmd_t                  cmd_i,
  output mcgd_pkg::sts_t                       sts_o,
  output logic [mcgd_pkg::M_TDATA_W-1:0]       out_data_o,
  output logic                                 out_slot_valid_o
);

  // only the lowest MAX_REPORT slots are ever addressable or reported
  localparam int unsigned TAB_DEPTH = (NUM_MODULES < mcgd_pkg::MAX_REPORT) ?
                                      NUM_MODULES : mcgd_pkg::MAX_REPORT;
  localparam int unsigned AW = (TAB_DEPTH > 1) ? $clog2(TAB_DEPTH) : 1;
  localparam int unsigned SW = $clog2(NUM_MODULES + 1);
  localparam int unsigned GW = 8;

  localparam int unsigned IDX_W  = mcgd_pkg::IDX_W;
  localparam int unsigned OFF_W  = mcgd_pkg::OFF_W;
  localparam int unsigned SLOT_W = mcgd_pkg::SLOT_W;
  localparam int unsigned CNT_W  = mcgd_pkg::CNT_W;
  localparam int unsigned VAL_W  = mcgd_pkg::VAL_W;
  localparam int unsigned RCW    = mcgd_pkg::RCW;

  // input fields
  logic [IDX_W-1:0]  in_idx, in_loc;
  logic [SLOT_W-1:0] in_slot;
  logic [CNT_W-1:0]  in_cnt;
  logic [VAL_W-1:0]  in_val;

  assign in_idx  = in_data_i[mcgd_pkg::S_IDX_LO  +: IDX_W];
  assign in_loc  = in_data_i[mcgd_pkg::S_LOC_LO  +: IDX_W];
  assign in_slot = in_data_i[mcgd_pkg::S_SLOT_LO +: SLOT_W];
  assign in_cnt  = in_data_i[mcgd_pkg::S_CNT_LO  +: CNT_W];
  assign in_val  = in_data_i[mcgd_pkg::S_VAL_LO  +: VAL_W];

  logic [mcgd_pkg::SEL_W-1:0] sel_q;
  logic [OFF_W-1:0]           loc_off_q;
  logic [IDX_W-1:0]           cur_idx_q;
  logic [mcgd_pkg::REC_W-1:0] rec_q, rec_d;
  logic [SW-1:0]              slots_q, slots_d;
  logic                       glitch_q;

  logic [OFF_W-1:0] rec_off_q;
  logic [AW-1:0]    rec_slot_q;
  logic             rec_en_q;

  logic [AW-1:0]    rep_idx_q;
  logic [RCW-1:0]   rep_n_q;
  logic             rep_empty_q;

  // offset table, entries without a valid bit read as zero
  logic [OFF_W-1:0] mem [TAB_DEPTH];
  logic [TAB_DEPTH-1:0] vld_q;
  logic [OFF_W-1:0] rdata_q;
  logic             rvld_q;
  logic [AW-1:0]    rd_addr;
  logic             rd_en;
  logic [OFF_W-1:0] tab_val;
  logic             tab_wr;

  logic [OFF_W-1:0] start_off, rec_off;
  logic             slot_ok;
  logic [RCW-1:0]   rep_n;

  assign start_off = {1'b0, in_loc} - {1'b0, in_idx};
  assign rec_off   = {{(OFF_W - VAL_W){1'b0}}, in_val} - {1'b0, cur_idx_q};
  assign slot_ok   = (GW'(in_slot) < GW'(NUM_MODULES));

  assign rd_addr = cmd_i.rd_rep ? rep_idx_q : in_slot[AW-1:0];
  assign rd_en   = cmd_i.rec_acc || cmd_i.rd_rep;
  assign tab_val = rvld_q ? rdata_q : '0;
  assign tab_wr  = cmd_i.rec_commit && rec_en_q && (tab_val != rec_off_q);

  // slot usage grows with the record count and the highest slot seen
  always_comb begin
    logic [GW-1:0] g, c1, c2;
    rec_d   = rec_q;
    slots_d = slots_q;
    g       = GW'(slots_q);
    c1      = '0;
    c2      = '0;
    if (cmd_i.start) begin
      rec_d = '0;
    end else if (cmd_i.rec_acc) begin
      rec_d = (rec_q == mcgd_pkg::REC_MAX) ? rec_q : rec_q + 1'b1;
      c1    = (GW'(rec_d) > GW'(NUM_MODULES)) ? GW'(NUM_MODULES) : GW'(rec_d);
      c2    = GW'(in_slot) + 1'b1;
      if (c1 > g) begin
        g = c1;
      end
      if (slot_ok && (c2 > g)) begin
        g = c2;
      end
      slots_d = SW'(g);
    end
  end

  always_comb begin
    if (GW'(slots_q) > GW'(mcgd_pkg::MAX_REPORT)) begin
      rep_n = RCW'(mcgd_pkg::MAX_REPORT);
    end else begin
      rep_n = RCW'(slots_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q       <= '0;
      loc_off_q   <= '0;
      cur_idx_q   <= '0;
      rec_q       <= '0;
      slots_q     <= '0;
      glitch_q    <= 1'b0;
      vld_q       <= '0;
      rec_en_q    <= 1'b0;
      rep_idx_q   <= '0;
      rep_n_q     <= '0;
      rep_empty_q <= 1'b0;
    end else begin
      rec_q   <= rec_d;
      slots_q <= slots_d;
      if (cfg_we_i) begin
        sel_q <= cfg_wdata_i;
      end
      if (cmd_i.start) begin
        cur_idx_q <= in_idx;
        glitch_q  <= (start_off != loc_off_q);
        loc_off_q <= start_off;
      end
      if (cmd_i.rec_acc) begin
        rec_en_q <= slot_ok && (in_cnt > CNT_W'(sel_q));
      end
      if (tab_wr) begin
        glitch_q          <= 1'b1;
        vld_q[rec_slot_q] <= 1'b1;
      end
      if (cmd_i.end_evt) begin
        glitch_q <= 1'b0;
      end
      if (cmd_i.rep_start) begin
        rep_idx_q   <= '0;
        rep_n_q     <= rep_n;
        rep_empty_q <= (rep_n == '0);
      end else if (cmd_i.rep_next) begin
        rep_idx_q <= rep_idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rec_acc) begin
      rec_off_q  <= rec_off;
      rec_slot_q <= in_slot[AW-1:0];
    end
    if (tab_wr) begin
      mem[rec_slot_q] <= rec_off_q;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
      rvld_q  <= vld_q[rd_addr];
    end
  end

  assign sts_o.glitch   = glitch_q;
  assign sts_o.rep_last = rep_empty_q || ((RCW'(rep_idx_q) + 1'b1) == rep_n_q);

  assign out_slot_valid_o = !rep_empty_q;

  always_comb begin
    out_data_o = '0;
    out_data_o[mcgd_pkg::M_IDX_LO  +: IDX_W] = cur_idx_q;
    out_data_o[mcgd_pkg::M_LOFF_LO +: OFF_W] = loc_off_q;
    if (!rep_empty_q) begin
      out_data_o[mcgd_pkg::M_SLOT_LO +: SLOT_W] = SLOT_W'(rep_idx_q);
      out_data_o[mcgd_pkg::M_SOFF_LO +: OFF_W]  = tab_val;
    end
  end

endmodule

`default_nettype wire

>>> src/mcgd_checker.sv
`default_nettype none

module mcgd_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic [mcgd_pkg::FUNC_W-1:0]     s_axis_tuser,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [mcgd_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  input wire logic [0:0]                      m_axis_tuser,
  input wire logic                            m_axis_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // no input is taken while a report is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready during report");

  // a counter record occupies the block for its write-back cycle
  a_rec_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == mcgd_pkg::FUNC_RECORD)
      |=> !s_axis_tready)
    else $error("record accepted without write-back cycle");

  // report with no slots in use is one result with cleared slot fields
  a_empty_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast
      && (m_axis_tdata[mcgd_pkg::M_SLOT_LO +: mcgd_pkg::SLOT_W] == '0)
      && (m_axis_tdata[mcgd_pkg::M_SOFF_LO +: mcgd_pkg::OFF_W] == '0))
    else $error("empty report malformed");

  // the next result after a non-final one is a reported slot, never the empty marker
  a_report_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> !s_axis_tready && m_axis_tuser[0])
    else $error("report ended early");

endmodule

bind module_counter_glitch_detector mcgd_checker u_mcgd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
